// ===== hw/rtl/hpt_pkg.sv =====
// shared types and constants for the homogeneous point transform
`default_nettype none
package hpt_pkg;
    localparam int DATA_WIDTH_DEF = 48;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int THR_W          = 47;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 64;

    localparam logic [PADDR_W-1:0] ADDR_ZERO_THRESHOLD = 4'h0;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_IDENT  = 2'd1,
        REQ_POINT  = 2'd2,
        REQ_VECTOR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NULL = 2'd1,
        ST_INF  = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef struct packed {
        logic       xf;
        t_status    st;
        logic [2:0] neg;
        logic [2:0] ovf;
    } t_side;
endpackage
`default_nettype wire

// ===== hw/rtl/homogeneous_point_transform.sv =====
// 4x4 homogeneous point transform: matrix store, multiply pipeline, pipelined divide
`default_nettype none
// Holds a 4x4 fixed-point matrix (identity after reset) and streams transactions
// through a fully pipelined datapath: one transaction enters per cycle unless the
// output stalls. The depth is set by the restoring divider, which resolves one
// quotient bit per stage for each of x, y and z; ahead of it sit split
// partial-product multipliers, the row sums, the magnitude and threshold stage, the
// scaled numerators and the overflow check. Element writes and identity loads take
// effect for the very next transaction. A stall on the output freezes the whole
// pipeline. zero_threshold lies at byte address 0.
module homogeneous_point_transform #(
    parameter int DATA_WIDTH = hpt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [1:0]                     i_row_index,
    input  wire logic [1:0]                     i_col_index,
    input  wire logic signed [DATA_WIDTH-1:0]   i_coef_value,
    input  wire logic signed [DATA_WIDTH-1:0]   i_in_x,
    input  wire logic signed [DATA_WIDTH-1:0]   i_in_y,
    input  wire logic signed [DATA_WIDTH-1:0]   i_in_z,
    input  wire logic                           i_in_is_null,
    input  wire logic                           i_in_is_cartesian,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [DATA_WIDTH-1:0]        o_out_x,
    output logic signed [DATA_WIDTH-1:0]        o_out_y,
    output logic signed [DATA_WIDTH-1:0]        o_out_z,
    output logic [1:0]                          o_status_code,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hpt_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [hpt_pkg::PDATA_W-1:0]    pwdata,
    output logic [hpt_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import hpt_pkg::*;

    localparam int D  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int L  = D / 2;
    localparam int HW = D - L;
    localparam int PW = 2 * D;
    localparam int AW = PW + 2;
    localparam int NW = AW + F + 1;
    localparam int XW = NW + D;
    localparam int TW = AW + F + THR_W;
    localparam logic [D-1:0] DMAX    = {1'b0, {(D-1){1'b1}}};
    localparam logic [D-1:0] DMIN    = {1'b1, {(D-1){1'b0}}};
    localparam logic [D-1:0] ONE_VAL = (F < D - 1) ? (D'(1) << F) : DMAX;

    // configuration
    logic [THR_W-1:0] r_thr;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_ZERO_THRESHOLD) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_ZERO_THRESHOLD) begin
            prdata = PDATA_W'(r_thr);
        end
    end

    // pipeline control
    logic en, in_acc;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;
    logic r_vd [0:D];
    assign en      = !r_vo || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vo;
    assign in_acc  = i_valid && en;

    // matrix store
    logic signed [D-1:0] r_mat [0:15];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < 16; e++) begin
                r_mat[e] <= (e % 5 == 0) ? ONE_VAL : '0;
            end
        end else if (in_acc) begin
            case (t_req'(i_req_type))
                REQ_WRITE: r_mat[{i_row_index, i_col_index}] <= i_coef_value;
                REQ_IDENT: begin
                    for (int e = 0; e < 16; e++) begin
                        r_mat[e] <= (e % 5 == 0) ? ONE_VAL : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // stage 1: partial products
    logic signed [2*HW-1:0]   n_hh [0:3][0:2];
    logic signed [HW+L:0]     n_hl [0:3][0:2];
    logic signed [HW+L:0]     n_lh [0:3][0:2];
    logic        [2*L-1:0]    n_ll [0:3][0:2];
    logic signed [D-1:0]      n_t  [0:3];
    logic signed [2*HW-1:0]   r_hh [0:3][0:2];
    logic signed [HW+L:0]     r_hl [0:3][0:2];
    logic signed [HW+L:0]     r_lh [0:3][0:2];
    logic        [2*L-1:0]    r_ll [0:3][0:2];
    logic signed [D-1:0]      r_t1 [0:3];
    t_side                    n_s1, r_s1;
    logic signed [D-1:0]      vin  [0:2];

    always_comb begin
        vin[0] = i_in_x;
        vin[1] = i_in_y;
        vin[2] = i_in_z;
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_hh[r][k] = $signed(r_mat[r*4+k][D-1:L]) * $signed(vin[k][D-1:L]);
                n_hl[r][k] = $signed(r_mat[r*4+k][D-1:L]) * $signed({1'b0, vin[k][L-1:0]});
                n_lh[r][k] = $signed({1'b0, r_mat[r*4+k][L-1:0]}) * $signed(vin[k][D-1:L]);
                n_ll[r][k] = r_mat[r*4+k][L-1:0] * vin[k][L-1:0];
            end
            // free vectors drop the translation column
            n_t[r] = (t_req'(i_req_type) == REQ_VECTOR && r < 3) ? '0 : r_mat[r*4+3];
        end
        n_s1 = '0;
        n_s1.st = ST_OK;
        if (t_req'(i_req_type) == REQ_POINT || t_req'(i_req_type) == REQ_VECTOR) begin
            if (i_in_is_null || !i_in_is_cartesian) begin
                n_s1.st = ST_NULL;
            end else begin
                n_s1.xf = 1'b1;
            end
        end
    end

    // stage 2: products
    logic signed [PW-1:0] n_p [0:3][0:2];
    logic signed [PW-1:0] r_p [0:3][0:2];
    logic signed [D-1:0]  r_t2 [0:3];
    t_side                r_s2;
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_p[r][k] = (PW'(r_hh[r][k]) << (2*L)) + (PW'(r_hl[r][k]) << L)
                          + (PW'(r_lh[r][k]) << L) + PW'($signed({1'b0, r_ll[r][k]}));
            end
        end
    end

    // stage 3: row sums
    logic signed [AW-1:0] n_acc [0:3];
    logic signed [AW-1:0] r_acc [0:3];
    t_side                r_s3;
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_acc[r] = AW'(r_p[r][0]) + AW'(r_p[r][1]) + AW'(r_p[r][2])
                     + (AW'(r_t2[r]) << F);
        end
    end

    // stage 4: magnitudes and zero test on w
    logic [AW-1:0] n_mag [0:3];
    logic          n_inf;
    t_side         n_s4, r_s4;
    logic [AW-1:0] r_an [0:2];
    logic [AW-1:0] r_d4;
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_mag[r] = r_acc[r][AW-1] ? AW'(-r_acc[r]) : AW'(r_acc[r]);
        end
        n_inf = TW'(n_mag[3]) <= (TW'(r_thr) << F);
        n_s4 = r_s3;
        for (int k = 0; k < 3; k++) begin
            n_s4.neg[k] = r_acc[k][AW-1] ^ r_acc[3][AW-1];
        end
        if (r_s3.xf && n_inf) begin
            n_s4.xf = 1'b0;
            n_s4.st = ST_INF;
        end
    end

    // stage 5: scaled numerators with rounding offset
    logic [NW-1:0] r_n [0:2];
    logic [AW-1:0] r_d5;
    t_side         r_s5;

    // stage 6 feeds divider slot 0: overflow check
    logic [XW-1:0] r_rem [0:D][0:2];
    logic [D-1:0]  r_q   [0:D][0:2];
    logic [AW-1:0] r_dd  [0:D];
    t_side         r_sd  [0:D];
    t_side         n_s6;
    always_comb begin
        n_s6 = r_s5;
        for (int k = 0; k < 3; k++) begin
            n_s6.ovf[k] = XW'(r_n[k]) >= (XW'(r_d5) << D);
        end
    end

    // divider: one quotient bit per stage
    logic [XW-1:0] n_rem [0:D-1][0:2];
    logic [D-1:0]  n_q   [0:D-1][0:2];
    logic [XW-1:0] n_sub [0:D-1];
    always_comb begin
        for (int j = 0; j < D; j++) begin
            n_sub[j] = XW'(r_dd[j]) << (D - 1 - j);
            for (int k = 0; k < 3; k++) begin
                n_rem[j][k] = r_rem[j][k];
                n_q[j][k]   = r_q[j][k];
                if (r_rem[j][k] >= n_sub[j]) begin
                    n_rem[j][k] = r_rem[j][k] - n_sub[j];
                    n_q[j][k]   = r_q[j][k] | (D'(1) << (D - 1 - j));
                end
            end
        end
    end

    // output stage: sign, saturation, status
    logic signed [D-1:0] n_o [0:2];
    logic [2:0]          n_sat;
    logic [D-1:0]        n_lim [0:2];
    logic [1:0]          n_st;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lim[k] = r_sd[D].neg[k] ? DMIN : DMAX;
            n_sat[k] = r_sd[D].ovf[k] || (r_q[D][k] > n_lim[k]);
            if (!r_sd[D].xf) begin
                n_o[k] = '0;
            end else if (n_sat[k]) begin
                n_o[k] = r_sd[D].neg[k] ? DMIN : DMAX;
            end else begin
                n_o[k] = r_sd[D].neg[k] ? -r_q[D][k] : r_q[D][k];
            end
        end
        if (!r_sd[D].xf) begin
            n_st = r_sd[D].st;
        end else if (|n_sat) begin
            n_st = ST_SAT;
        end else begin
            n_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
            for (int j = 0; j <= D; j++) begin
                r_vd[j] <= 1'b0;
            end
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_vd[0] <= r_v5;
            for (int j = 0; j < D; j++) begin
                r_vd[j+1] <= r_vd[j];
            end
            r_vo <= r_vd[D];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
            r_t1 <= n_t;
            r_s1 <= n_s1;
            r_p  <= n_p;
            r_t2 <= r_t1;
            r_s2 <= r_s1;
            r_acc <= n_acc;
            r_s3  <= r_s2;
            for (int k = 0; k < 3; k++) begin
                r_an[k] <= n_mag[k];
            end
            r_d4 <= n_mag[3];
            r_s4 <= n_s4;
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= (NW'(r_an[k]) << F) + NW'(r_d4 >> 1);
            end
            r_d5 <= r_d4;
            r_s5 <= r_s4;
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= XW'(r_n[k]);
                r_q[0][k]   <= '0;
            end
            r_dd[0] <= r_d5;
            r_sd[0] <= n_s6;
            for (int j = 0; j < D; j++) begin
                r_rem[j+1] <= n_rem[j];
                r_q[j+1]   <= n_q[j];
                r_dd[j+1]  <= r_dd[j];
                r_sd[j+1]  <= r_sd[j];
            end
            o_out_x       <= n_o[0];
            o_out_y       <= n_o[1];
            o_out_z       <= n_o[2];
            o_status_code <= n_st;
        end
    end

    // a result flagged at infinity or as a null input carries zero coordinates
    a_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status_code == ST_INF || o_status_code == ST_NULL)
        |-> o_out_x == '0 && o_out_y == '0 && o_out_z == '0)
        else $error("special status with nonzero coordinates");

    // a saturated result has at least one coordinate at a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status_code == ST_SAT
        |-> (o_out_x == DMAX || o_out_x == DMIN || o_out_y == DMAX || o_out_y == DMIN
             || o_out_z == DMAX || o_out_z == DMIN))
        else $error("saturation flagged without a limit value");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire
